// ===== hdl/atss_pkg.sv =====
// atss_pkg: shared types, constants and command codes of the span sampler
// used by atss_ctrl, atss_dpath and the top level of the affine texture span sampler
// no dependencies
`default_nettype none

package atss_pkg;

  // defaults for the top level parameters
  localparam int TEX_DIM_DEF   = 64;
  localparam int MAX_SPAN_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int COEF_W    = 32;
  localparam int ACC_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int DIMREG_W  = 7;
  localparam int POS_W     = 12;
  localparam int CNT_IN_W  = 7;
  localparam int CTR_W     = POS_W + 1;        // 2*pos+1
  localparam int PROD_W    = COEF_W + CTR_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TW = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TH = 3'd7;

  // request modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SHADE = 1'b1;

  // multiplier operand selection during setup
  localparam logic [1:0] MUL_SX_CX = 2'd0;
  localparam logic [1:0] MUL_KX_CY = 2'd1;
  localparam logic [1:0] MUL_KY_CX = 2'd2;
  localparam logic [1:0] MUL_SY_CY = 2'd3;

  typedef struct packed {
    logic               mode;
    logic [POS_W-1:0]   dev_x;
    logic [POS_W-1:0]   dev_y;
    logic [CNT_IN_W-1:0] span_count;
    logic [POS_W-1:0]   texel_index;
    logic [31:0]        texel_value;
  } in_req_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } out_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic       wr_en;    // store one texel from the request
    logic       load;     // capture pixel center, preset accumulators
    logic       mul_en;   // register one setup product
    logic [1:0] mul_sel;
    logic       add_en;   // fold product register into an accumulator
    logic       add_v;    // 1: into v, 0: into u
    logic       issue;    // fetch texel at current u,v and step
  } dp_cmd_t;

endpackage : atss_pkg

`default_nettype wire

// ===== hdl/atss_ram.sv =====
// atss_ram: generic single write port, single read port RAM, registered read
// no dependencies
`default_nettype none

module atss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : atss_ram

`default_nettype wire

// ===== hdl/atss_ctrl.sv =====
// atss_ctrl: request sequencing state machine of the span sampler
// depends on atss_pkg; drives atss_dpath through dp_cmd_t
`default_nettype none

module atss_ctrl
  import atss_pkg::*;
#(
  parameter int MAX_SPAN = MAX_SPAN_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                mode,
  input  wire logic [CNT_IN_W-1:0] span_count,
  output      logic                busy,
  output      dp_cmd_t             cmd,
  output      logic                out_valid,
  output      logic                out_last
);

  localparam int CNT_W = $clog2(MAX_SPAN + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_TAIL = 4'b0100,
    ST_SPAN = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             valid_r, valid_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] cnt_sat;
  logic             accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    if (span_count > CNT_IN_W'(MAX_SPAN)) begin
      cnt_sat = CNT_W'(MAX_SPAN);
    end else begin
      cnt_sat = CNT_W'(span_count);
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    valid_nxt = 1'b0;
    last_nxt  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.load = 1'b1;
            cnt_nxt  = cnt_sat;
            step_nxt = MUL_SX_CX;
            // an empty span gives nothing
            if (cnt_sat != '0) begin
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = step_r;
        // product of the previous step lands now
        cmd.add_en  = (step_r != MUL_SX_CX);
        cmd.add_v   = (step_r == MUL_SY_CY);
        step_nxt    = step_r + 2'd1;
        if (step_r == MUL_SY_CY) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd.add_en = 1'b1;
        cmd.add_v  = 1'b1;
        state_nxt  = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.issue = 1'b1;
        valid_nxt = 1'b1;
        last_nxt  = (cnt_r == CNT_W'(1));
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_last  = last_r;

endmodule : atss_ctrl

`default_nettype wire

// ===== hdl/atss_dpath.sv =====
// atss_dpath: configuration registers, setup multiplier, u/v accumulators,
// clamp and address logic, texel memory; depends on atss_pkg and atss_ram
`default_nettype none

module atss_dpath
  import atss_pkg::*;
#(
  parameter int TEX_DIM   = TEX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire in_req_t              in_req,
  input  wire dp_cmd_t              cmd,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output      logic [31:0]          pixel
);

  localparam int DEPTH   = TEX_DIM * TEX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COORD_W = $clog2(TEX_DIM);
  localparam int DIM_W   = $clog2(TEX_DIM + 1);
  localparam int CMP_W   = (DIM_W > DIMREG_W) ? DIM_W : DIMREG_W;
  localparam int WHOLE_W = ACC_W - FRAC_BITS - 1;

  logic signed [COEF_W-1:0] sx_r, kx_r, tx_r, ky_r, sy_r, ty_r;
  logic [DIMREG_W-1:0]      tw_r, th_r;
  logic [CTR_W-1:0]         cx_r, cy_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]         u_r, u_nxt, v_r, v_nxt;
  logic signed [COEF_W-1:0] mul_a;
  logic signed [CTR_W:0]    mul_b;
  logic [ACC_W-1:0]         prod_ext;
  logic [CMP_W-1:0]         w_m1, h_m1;
  logic [COORD_W-1:0]       col, row;
  logic [ADDR_W-1:0]        raddr;
  logic                     idx_ok;

  function automatic logic [CMP_W-1:0] dim_m1(input logic [DIMREG_W-1:0] d);
    logic [CMP_W-1:0] lim;
    lim = CMP_W'(d);
    if (lim == '0) begin
      lim = CMP_W'(1);
    end else if (lim > CMP_W'(TEX_DIM)) begin
      lim = CMP_W'(TEX_DIM);
    end
    return lim - CMP_W'(1);
  endfunction

  // clamp to [0, dim-1] then take the integer part
  function automatic logic [COORD_W-1:0] tex_coord(input logic [ACC_W-1:0] acc,
                                                   input logic [CMP_W-1:0] lim_m1);
    logic [WHOLE_W-1:0] whole;
    logic [WHOLE_W-1:0] lim;
    whole = acc[ACC_W-1:FRAC_BITS+1];
    lim   = WHOLE_W'(lim_m1);
    if (acc[ACC_W-1]) begin
      return '0;
    end else if (whole > lim) begin
      return COORD_W'(lim);
    end else begin
      return COORD_W'(whole);
    end
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= COEF_W'(1) <<< FRAC_BITS;
      kx_r <= '0;
      tx_r <= '0;
      ky_r <= '0;
      sy_r <= COEF_W'(1) <<< FRAC_BITS;
      ty_r <= '0;
      tw_r <= DIMREG_W'(64);
      th_r <= DIMREG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SX:  sx_r <= cfg_wdata[COEF_W-1:0];
        REG_KX:  kx_r <= cfg_wdata[COEF_W-1:0];
        REG_TX:  tx_r <= cfg_wdata[COEF_W-1:0];
        REG_KY:  ky_r <= cfg_wdata[COEF_W-1:0];
        REG_SY:  sy_r <= cfg_wdata[COEF_W-1:0];
        REG_TY:  ty_r <= cfg_wdata[COEF_W-1:0];
        REG_TW:  tw_r <= cfg_wdata[DIMREG_W-1:0];
        REG_TH:  th_r <= cfg_wdata[DIMREG_W-1:0];
        default: ;
      endcase
    end
  end

  // setup multiplier, one product per cycle
  always_comb begin
    case (cmd.mul_sel)
      MUL_SX_CX: begin
        mul_a = sx_r;
        mul_b = {1'b0, cx_r};
      end
      MUL_KX_CY: begin
        mul_a = kx_r;
        mul_b = {1'b0, cy_r};
      end
      MUL_KY_CX: begin
        mul_a = ky_r;
        mul_b = {1'b0, cx_r};
      end
      MUL_SY_CY: begin
        mul_a = sy_r;
        mul_b = {1'b0, cy_r};
      end
      default: begin
        mul_a = sx_r;
        mul_b = {1'b0, cx_r};
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    if (cmd.load) begin
      // translation counts twice at one extra fraction bit
      u_nxt = {{(ACC_W-COEF_W-1){tx_r[COEF_W-1]}}, tx_r, 1'b0};
      v_nxt = {{(ACC_W-COEF_W-1){ty_r[COEF_W-1]}}, ty_r, 1'b0};
    end else if (cmd.add_en) begin
      if (cmd.add_v) begin
        v_nxt = v_r + prod_ext;
      end else begin
        u_nxt = u_r + prod_ext;
      end
    end else if (cmd.issue) begin
      u_nxt = u_r + {{(ACC_W-COEF_W-1){sx_r[COEF_W-1]}}, sx_r, 1'b0};
      v_nxt = v_r + {{(ACC_W-COEF_W-1){ky_r[COEF_W-1]}}, ky_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= {in_req.dev_x, 1'b1};
      cy_r <= {in_req.dev_y, 1'b1};
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    u_r <= u_nxt;
    v_r <= v_nxt;
  end

  always_comb begin
    w_m1  = dim_m1(tw_r);
    h_m1  = dim_m1(th_r);
    col   = tex_coord(u_r, w_m1);
    row   = tex_coord(v_r, h_m1);
    raddr = ADDR_W'(row) * ADDR_W'(TEX_DIM) + ADDR_W'(col);
  end

  assign idx_ok = (32'(in_req.texel_index) < 32'(DEPTH));

  atss_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_texels (
    .clk   (clk),
    .we    (cmd.wr_en && idx_ok),
    .waddr (ADDR_W'(in_req.texel_index)),
    .wdata (in_req.texel_value),
    .re    (cmd.issue),
    .raddr (raddr),
    .rdata (pixel)
  );

endmodule : atss_dpath

`default_nettype wire

// ===== hdl/affine_texture_span_sampler.sv =====
// affine_texture_span_sampler: nearest-neighbor texture span sampler, top level
// depends on atss_pkg, atss_ctrl, atss_dpath (which holds atss_ram)
//
// usage:
//   in_req is taken at a clock edge where start is high and busy is low.
//   mode write stores texel_value at texel_index; an index past the bitmap
//   is dropped and no result is produced.
//   mode shade maps pixel centers of the row span through the affine
//   coefficients and produces one result per pixel on out_rsp, flagged by a
//   single-cycle out_valid; out_rsp.last marks the final pixel.
//   the first result follows the four setup products through one 32x14
//   multiplier, the last fold into v and the registered texel memory read;
//   after that one result every cycle.
//   a shade request keeps busy high through setup and its span; a write
//   request or a zero span_count leaves the block idle.
//   the texel memory is one write port and one read port, one texel fetch
//   per cycle.
//   cfg_we/cfg_index/cfg_wdata write a register at the clock edge; the user must
//   write only while no request is in progress, the block does not enforce it.
//   reset (rst_n low, synchronous) returns to idle and loads the unit
//   matrix and a 64x64 clamp size; texel contents are kept and undefined
//   until written. results cannot be held off by the receiver.
`default_nettype none

module affine_texture_span_sampler
  import atss_pkg::*;
#(
  parameter int TEX_DIM   = TEX_DIM_DEF,
  parameter int MAX_SPAN  = MAX_SPAN_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire in_req_t              in_req,
  output      logic                 out_valid,
  output      out_rsp_t             out_rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  dp_cmd_t     cmd;
  logic        last;
  logic [31:0] pixel;

  atss_ctrl #(
    .MAX_SPAN (MAX_SPAN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .mode       (in_req.mode),
    .span_count (in_req.span_count),
    .busy       (busy),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_last   (last)
  );

  atss_dpath #(
    .TEX_DIM   (TEX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pixel     (pixel)
  );

  assign out_rsp.pixel = pixel;
  assign out_rsp.last  = last;

endmodule : affine_texture_span_sampler

`default_nettype wire

// ===== verif/tb_affine_texture_span_sampler.sv =====
// tb_affine_texture_span_sampler: self-checking testbench for the texture span sampler
// predicts sampled texels from its own copy of the bitmap and coefficient registers
// depends on atss_pkg and affine_texture_span_sampler

module tb_affine_texture_span_sampler;
  timeunit 1ns;
  timeprecision 1ps;
  import atss_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int DEPTH          = TEX_DIM_DEF * TEX_DIM_DEF;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_req_t              in_req    = '0;
  logic                 out_valid;
  out_rsp_t             out_rsp;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // shadow of the coefficient and size registers
  logic signed [31:0] sx_q = 32'sd65536;
  logic signed [31:0] kx_q = 32'sd0;
  logic signed [31:0] tx_q = 32'sd0;
  logic signed [31:0] ky_q = 32'sd0;
  logic signed [31:0] sy_q = 32'sd65536;
  logic signed [31:0] ty_q = 32'sd0;
  logic [6:0]         tw_q = 7'd64;
  logic [6:0]         th_q = 7'd64;

  logic [31:0] texel_mem [DEPTH];
  bit          texel_seen [DEPTH];

  in_req_t  request_q[$];
  out_rsp_t pixel_expect_q[$];

  int mismatches  = 0;
  int idle_cycles = 0;
  bit steady_run  = 1'b0;

  affine_texture_span_sampler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint wrap48(longint x);
    logic signed [47:0] t;
    t = x[47:0];
    return longint'(t);
  endfunction

  function automatic int unsigned dim_limit(logic [6:0] d);
    if (d == 7'd0) return 1;
    if (d > TEX_DIM_DEF) return TEX_DIM_DEF;
    return 32'(d);
  endfunction

  function automatic int span_len(logic [CNT_IN_W-1:0] c);
    return (c > MAX_SPAN_DEF) ? MAX_SPAN_DEF : int'(c);
  endfunction

  // clamp then floor; accumulators carry one extra fraction bit
  function automatic int unsigned clamp_coord(longint acc, int unsigned dim);
    longint whole;
    if (acc < 0) return 0;
    whole = acc >>> (FRAC_BITS_DEF + 1);
    if (whole > longint'(dim) - 1) return dim - 1;
    return int'(whole);
  endfunction

  function automatic void span_origin(in_req_t r, output longint u, output longint v);
    longint cx, cy;
    cx = 2 * longint'(r.dev_x) + 1;
    cy = 2 * longint'(r.dev_y) + 1;
    u = wrap48(longint'(sx_q) * cx + longint'(kx_q) * cy + 2 * longint'(tx_q));
    v = wrap48(longint'(ky_q) * cx + longint'(sy_q) * cy + 2 * longint'(ty_q));
  endfunction

  function automatic void span_step(inout longint u, inout longint v);
    u = wrap48(u + 2 * longint'(sx_q));
    v = wrap48(v + 2 * longint'(ky_q));
  endfunction

  function automatic int unsigned texel_addr(longint u, longint v);
    return clamp_coord(v, dim_limit(th_q)) * TEX_DIM_DEF + clamp_coord(u, dim_limit(tw_q));
  endfunction

  function automatic void predict_request(in_req_t r);
    longint u, v;
    int     n;
    out_rsp_t e;
    if (r.mode == MODE_WRITE) begin
      texel_mem[r.texel_index] = r.texel_value;
      return;
    end
    n = span_len(r.span_count);
    span_origin(r, u, v);
    for (int i = 0; i < n; i++) begin
      e.pixel = texel_mem[POS_W'(texel_addr(u, v))];
      e.last  = (i == n - 1);
      pixel_expect_q.push_back(e);
      span_step(u, v);
    end
  endfunction

  task automatic queue_write(int unsigned idx, logic [31:0] val);
    in_req_t r;
    r             = '0;
    r.mode        = MODE_WRITE;
    r.dev_x       = POS_W'($urandom);
    r.dev_y       = POS_W'($urandom);
    r.span_count  = CNT_IN_W'($urandom);
    r.texel_index = idx[POS_W-1:0];
    r.texel_value = val;
    texel_seen[r.texel_index] = 1'b1;
    request_q.push_back(r);
  endtask

  // any texel the span will touch gets written first
  task automatic queue_shade(int unsigned x, int unsigned y, int unsigned cnt);
    in_req_t     r;
    longint      u, v;
    int unsigned a;
    r.mode        = MODE_SHADE;
    r.dev_x       = x[POS_W-1:0];
    r.dev_y       = y[POS_W-1:0];
    r.span_count  = cnt[CNT_IN_W-1:0];
    r.texel_index = POS_W'($urandom);
    r.texel_value = $urandom;
    span_origin(r, u, v);
    for (int i = 0; i < span_len(r.span_count); i++) begin
      a = texel_addr(u, v);
      if (!texel_seen[a[POS_W-1:0]]) queue_write(a, $urandom);
      span_step(u, v);
    end
    request_q.push_back(r);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SX: sx_q = val;
      REG_KX: kx_q = val;
      REG_TX: tx_q = val;
      REG_KY: ky_q = val;
      REG_SY: sy_q = val;
      REG_TY: ty_q = val;
      REG_TW: tw_q = val[6:0];
      REG_TH: th_q = val[6:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [31:0] sx, logic [31:0] kx, logic [31:0] tx,
                             logic [31:0] ky, logic [31:0] sy, logic [31:0] ty,
                             logic [31:0] tw, logic [31:0] th);
    write_reg(REG_SX, sx);
    write_reg(REG_KX, kx);
    write_reg(REG_TX, tx);
    write_reg(REG_KY, ky);
    write_reg(REG_SY, sy);
    write_reg(REG_TY, ty);
    write_reg(REG_TW, tw);
    write_reg(REG_TH, th);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every request taken and every pixel seen, then let the block go idle
  task automatic settle();
    while (request_q.size() != 0 || start || pixel_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef(int unsigned whole_max);
    int c;
    c = int'($urandom_range(0, 2 * whole_max * 65536)) - int'(whole_max * 65536);
    return c;
  endfunction

  task automatic random_items(int n);
    int unsigned x, y, cnt, sel;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 35) begin
        queue_write($urandom_range(DEPTH - 1), $urandom);
      end else begin
        x   = ($urandom_range(99) < 80) ? $urandom_range(0, 70) : $urandom_range(0, 4095);
        y   = ($urandom_range(99) < 80) ? $urandom_range(0, 70) : $urandom_range(0, 4095);
        sel = $urandom_range(99);
        if (sel < 10)      cnt = 0;
        else if (sel < 20) cnt = $urandom_range(64, 127);
        else if (sel < 30) cnt = $urandom_range(13, 63);
        else               cnt = $urandom_range(1, 12);
        queue_shade(x, y, cnt);
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start  <= 1'b0;
      in_req <= '0;
    end else begin
      if (start && !busy) predict_request(in_req);
      if (!start || !busy) begin
        if (request_q.size() != 0 && (steady_run || $urandom_range(99) >= 8)) begin
          start  <= 1'b1;
          in_req <= request_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // pixel monitor
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid) begin
      if (pixel_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel %h last %b", out_rsp.pixel, out_rsp.last);
      end else begin
        want = pixel_expect_q.pop_front();
        if (out_rsp.pixel !== want.pixel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected %h got %h", want.pixel, out_rsp.pixel);
        end
        if (out_rsp.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("last mismatch: expected %b got %b", want.last, out_rsp.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[affine_texture_span_sampler] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset matrix: field extremes, empty and saturated spans, edge clamps
    queue_write(0, 32'h0000_0000);
    queue_write(DEPTH - 1, 32'hFFFF_FFFF);
    queue_write(2730, 32'h5555_AAAA);
    queue_shade(0, 0, 1);
    queue_shade(4095, 4095, 1);
    queue_shade(0, 0, 0);
    queue_shade(60, 0, 64);
    queue_shade(60, 0, 127);
    queue_shade(4095, 4095, 65);
    queue_shade(4095, 0, 3);
    queue_shade(0, 63, 5);
    settle();

    // largest positive u, most negative v, size registers at zero and max
    load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd127);
    queue_shade(0, 0, 4);
    queue_shade(4095, 4095, 64);
    settle();

    // negative u clamps to column zero
    load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd127, 32'd0);
    queue_shade(0, 0, 4);
    queue_shade(4095, 4095, 64);
    settle();

    // half step in u, quarter step down in v: floor of fractional coordinates
    load_config(32'sd32768, 32'sd0, 32'sd196608, -32'sd16384, 32'sd65536,
                32'sd2621440, 32'd64, 32'd65);
    queue_shade(10, 20, 16);
    queue_shade(3, 1, 40);
    settle();

    for (int p = 0; p < 6; p++) begin
      if (p == 0)
        load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom_range(0, 127), $urandom_range(0, 127));
      else
        load_config(rand_coef(3), rand_coef(1), rand_coef(40),
                    rand_coef(1), rand_coef(3), rand_coef(40),
                    $urandom_range(0, 8), $urandom_range(0, 8));
      steady_run = (p == 3);
      random_items(8);
      settle();
    end

    if (mismatches == 0)
      $display("[affine_texture_span_sampler] OK");
    else
      $display("[affine_texture_span_sampler] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/atss_pkg.sv
hdl/atss_ram.sv
hdl/atss_ctrl.sv
hdl/atss_dpath.sv
hdl/affine_texture_span_sampler.sv
verif/tb_affine_texture_span_sampler.sv
